>>> rtl/bce_rml_pkg.sv
// shared constants, types and helper functions for the row mean cross-entropy loss block
package bce_rml_pkg;

  localparam int PRED_W        = 16;
  localparam int LABEL_W       = 17;
  localparam int LOSS_W        = 20;
  localparam int ROWIDX_W      = 16;
  localparam int RW_W          = 11;
  localparam int MAX_WIDTH_DEF = 1024;

  localparam int MANT_W    = 16;
  localparam int EXP_W     = 4;
  localparam int NLOG_W    = 21;
  localparam int LN_W      = 20;
  localparam int OPA_W     = 21;
  localparam int OPB_W     = 17;
  localparam int PROD_W    = 38;
  localparam int SQR_STEPS = 16;
  localparam int FRAC_SH   = 16;

  localparam logic [LABEL_W-1:0] ONE_Q16  = 17'd65536;
  localparam logic [15:0]        LN2_Q16  = 16'd45426;
  localparam logic [LOSS_W-1:0]  LOSS_MAX = 20'hFFFFF;

  localparam logic [1:0] OP_SQR = 2'd0;
  localparam logic [1:0] OP_LN  = 2'd1;
  localparam logic [1:0] OP_MAC = 2'd2;

  typedef struct packed {
    logic [1:0]        op;
    logic [OPA_W-1:0]  opa;
    logic [OPB_W-1:0]  opb;
    logic [PROD_W-1:0] acc;
  } mul_req_t;

  typedef struct packed {
    logic [MANT_W-1:0] sqr_m;
    logic              sqr_bit;
    logic [LN_W-1:0]   ln;
    logic [PROD_W-1:0] mac;
  } mul_res_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [EXP_W-1:0] msb_index(input logic [MANT_W-1:0] x);
    logic [EXP_W-1:0] idx;
    idx = '0;
    for (int k = 0; k < MANT_W; k++) begin
      if (x[k]) idx = EXP_W'(k);
    end
    return idx;
  endfunction

  function automatic logic [MANT_W-1:0] normalise(input logic [MANT_W-1:0] x,
                                                 input logic [EXP_W-1:0] e);
    return x << (EXP_W'(MANT_W - 1) - e);
  endfunction

endpackage

>>> rtl/bce_rml_if.sv
// item channel interfaces: prediction/label input, row result output, width config
interface bce_rml_in_if;
  logic                             valid;
  logic                             ready;
  logic [bce_rml_pkg::PRED_W-1:0]   pred;
  logic [bce_rml_pkg::LABEL_W-1:0]  label;
  modport source (output valid, output pred, output label, input ready);
  modport sink   (input valid, input pred, input label, output ready);
endinterface

interface bce_rml_out_if;
  logic                              valid;
  logic                              ready;
  logic [bce_rml_pkg::LOSS_W-1:0]    row_loss;
  logic [bce_rml_pkg::ROWIDX_W-1:0]  row_index;
  modport source (output valid, output row_loss, output row_index, input ready);
  modport sink   (input valid, input row_loss, input row_index, output ready);
endinterface

interface bce_rml_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bce_rml_pkg::RW_W-1:0]  row_width;
  modport source (output valid, output row_width, input ready);
  modport sink   (input valid, input row_width, output ready);
endinterface

>>> rtl/bce_row_mean_loss_top.sv
// row mean binary cross-entropy loss, top level with sequencer and row state
//
//   port    | dir | handshake   | payload
//   in_ch   | in  | valid/ready | pred q0.16, label q1.16
//   out_ch  | out | valid/ready | row_loss q4.16, row_index
//   cfg_ch  | in  | valid/ready | row_width
//
// each item runs two 16-step squaring logarithms and four
// multiplies, all on the one shared multiplier
// the last item of a row adds the bit-serial divide by the row width and
// the result load
// rst_n is synchronous; a finished result waits in the output register while
// new items are taken, and the sequencer stalls only if a second result is due
module bce_row_mean_loss_top #(
  parameter int MAX_WIDTH = bce_rml_pkg::MAX_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  bce_rml_in_if.sink    in_ch,
  bce_rml_out_if.source out_ch,
  bce_rml_cfg_if.sink   cfg_ch
);
  import bce_rml_pkg::*;

  localparam int CNT_W  = $clog2(MAX_WIDTH + 1);
  localparam int SUM_W  = LOSS_W + CNT_W;
  localparam int STEP_W = $clog2(SQR_STEPS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQR  = 3'd1;
  localparam logic [2:0] S_LN   = 3'd2;
  localparam logic [2:0] S_MA   = 3'd3;
  localparam logic [2:0] S_MB   = 3'd4;
  localparam logic [2:0] S_ACC  = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]          state_r, state_nxt;
  logic [RW_W-1:0]     width_r, width_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [ROWIDX_W-1:0] row_r, row_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [LOSS_W-1:0]   out_loss_r, out_loss_nxt;
  logic [ROWIDX_W-1:0] out_idx_r, out_idx_nxt;

  logic [MANT_W-1:0]   m_r, m_nxt;
  logic [EXP_W-1:0]    e_r, e_nxt;
  logic [MANT_W-1:0]   frac_r, frac_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                side_r, side_nxt;
  logic [MANT_W-1:0]   q_r, q_nxt;
  logic [LABEL_W-1:0]  y_r, y_nxt;
  logic [LN_W-1:0]     lnp_r, lnp_nxt;
  logic [LN_W-1:0]     lnq_r, lnq_nxt;
  logic [PROD_W-1:0]   acc_r, acc_nxt;
  logic [LOSS_W-1:0]   elem_r, elem_nxt;

  logic [PRED_W-1:0]   p_clip;
  logic [NLOG_W-1:0]   nlog2;
  logic [CNT_W-1:0]    w_eff;
  logic [CNT_W-1:0]    cnt_inc;
  logic [SUM_W-1:0]    sum_add;
  logic                row_end;
  logic [LOSS_W-1:0]   loss_sat;

  mul_req_t            mul_req;
  mul_res_t            mul_res;
  div_stat_t           div_stat;
  logic                div_start;
  logic [SUM_W-1:0]    div_quo;

  bce_rml_mul u_mul (
    .req (mul_req),
    .res (mul_res)
  );

  bce_rml_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_add),
    .divisor  (w_eff),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  assign p_clip  = (in_ch.pred == '0) ? PRED_W'(1) : in_ch.pred;
  assign nlog2   = {5'd16 - {1'b0, e_r}, 16'b0} - NLOG_W'(frac_r);
  assign cnt_inc = cnt_r + CNT_W'(1);
  assign sum_add = sum_r + SUM_W'(elem_r);
  assign row_end = cnt_inc >= w_eff;
  assign loss_sat = (|div_quo[SUM_W-1:LOSS_W]) ? LOSS_MAX : div_quo[LOSS_W-1:0];

  always_comb begin
    if (width_r == '0) begin
      w_eff = CNT_W'(1);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      w_eff = CNT_W'(MAX_WIDTH);
    end else begin
      w_eff = CNT_W'(width_r);
    end
  end

  assign in_ch.ready      = (state_r == S_IDLE);
  assign cfg_ch.ready     = 1'b1;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.row_loss  = out_loss_r;
  assign out_ch.row_index = out_idx_r;

  always_comb begin
    state_nxt     = state_r;
    width_nxt     = cfg_ch.valid ? cfg_ch.row_width : width_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    row_nxt       = row_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_loss_nxt  = out_loss_r;
    out_idx_nxt   = out_idx_r;
    m_nxt         = m_r;
    e_nxt         = e_r;
    frac_nxt      = frac_r;
    step_nxt      = step_r;
    side_nxt      = side_r;
    q_nxt         = q_r;
    y_nxt         = y_r;
    lnp_nxt       = lnp_r;
    lnq_nxt       = lnq_r;
    acc_nxt       = acc_r;
    elem_nxt      = elem_r;
    mul_req       = '0;
    div_start     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          y_nxt    = (in_ch.label > ONE_Q16) ? ONE_Q16 : in_ch.label;
          q_nxt    = MANT_W'(ONE_Q16 - LABEL_W'(p_clip));
          e_nxt    = msb_index(p_clip);
          m_nxt    = normalise(p_clip, msb_index(p_clip));
          frac_nxt = '0;
          step_nxt = '0;
          side_nxt = 1'b0;
          state_nxt = S_SQR;
        end
      end
      S_SQR: begin
        mul_req.op  = OP_SQR;
        mul_req.opa = OPA_W'(m_r);
        mul_req.opb = OPB_W'(m_r);
        m_nxt       = mul_res.sqr_m;
        frac_nxt    = {frac_r[MANT_W-2:0], mul_res.sqr_bit};
        step_nxt    = step_r + STEP_W'(1);
        if (step_r == STEP_W'(SQR_STEPS - 1)) begin
          state_nxt = S_LN;
        end
      end
      S_LN: begin
        mul_req.op  = OP_LN;
        mul_req.opa = nlog2;
        mul_req.opb = OPB_W'(LN2_Q16);
        if (!side_r) begin
          lnp_nxt   = mul_res.ln;
          side_nxt  = 1'b1;
          e_nxt     = msb_index(q_r);
          m_nxt     = normalise(q_r, msb_index(q_r));
          frac_nxt  = '0;
          step_nxt  = '0;
          state_nxt = S_SQR;
        end else begin
          lnq_nxt   = mul_res.ln;
          state_nxt = S_MA;
        end
      end
      S_MA: begin
        mul_req.op  = OP_MAC;
        mul_req.opa = OPA_W'(lnp_r);
        mul_req.opb = y_r;
        mul_req.acc = '0;
        acc_nxt     = mul_res.mac;
        state_nxt   = S_MB;
      end
      S_MB: begin
        mul_req.op  = OP_MAC;
        mul_req.opa = OPA_W'(lnq_r);
        mul_req.opb = ONE_Q16 - y_r;
        mul_req.acc = acc_r;
        elem_nxt    = (|mul_res.mac[PROD_W-1:LOSS_W+FRAC_SH]) ? LOSS_MAX
                    : mul_res.mac[LOSS_W+FRAC_SH-1:FRAC_SH];
        state_nxt   = S_ACC;
      end
      S_ACC: begin
        if (row_end) begin
          div_start = 1'b1;
          sum_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end else begin
          sum_nxt   = sum_add;
          cnt_nxt   = cnt_inc;
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_loss_nxt  = loss_sat;
          out_idx_nxt   = row_r;
          row_nxt       = row_r + ROWIDX_W'(1);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      width_r     <= RW_W'(1);
      sum_r       <= '0;
      cnt_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      width_r     <= width_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_loss_r <= out_loss_nxt;
    out_idx_r  <= out_idx_nxt;
    m_r        <= m_nxt;
    e_r        <= e_nxt;
    frac_r     <= frac_nxt;
    step_r     <= step_nxt;
    side_r     <= side_nxt;
    q_r        <= q_nxt;
    y_r        <= y_nxt;
    lnp_r      <= lnp_nxt;
    lnq_r      <= lnq_nxt;
    acc_r      <= acc_nxt;
    elem_r     <= elem_nxt;
  end

`ifndef SYNTHESIS
  a_mant_norm: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQR) |-> m_r[MANT_W-1]) else $error("mantissa left [1,2)");
  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> (state_r == S_DIV)) else $error("divider busy outside divide");
  a_row_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (cnt_r == '0 && sum_r == '0))
    else $error("row state not cleared at result");
`endif

endmodule

>>> rtl/bce_rml_mul.sv
// shared multiplier with squaring, log scaling and multiply-accumulate modes
module bce_rml_mul (
  input  bce_rml_pkg::mul_req_t req,
  output bce_rml_pkg::mul_res_t res
);
  import bce_rml_pkg::*;

  logic [PROD_W-1:0] prod;

  assign prod = PROD_W'(req.opa) * PROD_W'(req.opb);

  always_comb begin
    res = '0;
    case (req.op)
      OP_SQR: begin
        // square in q1.15, one fraction bit out, renormalise to [1,2)
        res.sqr_bit = prod[2*MANT_W-1];
        res.sqr_m   = prod[2*MANT_W-1] ? prod[2*MANT_W-1:MANT_W]
                                       : prod[2*MANT_W-2:MANT_W-1];
      end
      OP_LN: begin
        res.ln = prod[LN_W+FRAC_SH-1:FRAC_SH];
      end
      OP_MAC: begin
        res.mac = req.acc + prod;
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

>>> rtl/bce_rml_div.sv
// restoring divider, one quotient bit per cycle
module bce_rml_div #(
  parameter int DIVIDEND_W = 31,
  parameter int DIVISOR_W  = 11
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [DIVIDEND_W-1:0]         dividend,
  input  logic [DIVISOR_W-1:0]          divisor,
  output bce_rml_pkg::div_stat_t        stat,
  output logic [DIVIDEND_W-1:0]         quotient
);
  import bce_rml_pkg::*;

  localparam int STEP_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVISOR_W-1:0]  divisor_r, divisor_nxt;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;

  assign trial = {rem_r, quo_r[DIVIDEND_W-1]};
  assign ge    = trial >= {1'b0, divisor_r};
  assign diff  = trial - {1'b0, divisor_r};

  always_comb begin
    busy_nxt    = busy_r;
    done_nxt    = 1'b0;
    step_nxt    = step_r;
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;
    divisor_nxt = divisor_r;
    if (start) begin
      busy_nxt    = 1'b1;
      step_nxt    = '0;
      quo_nxt     = dividend;
      rem_nxt     = '0;
      divisor_nxt = divisor;
    end else if (busy_r) begin
      quo_nxt  = {quo_r[DIVIDEND_W-2:0], ge};
      rem_nxt  = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_W'(DIVIDEND_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r    <= step_nxt;
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
    divisor_r <= divisor_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider started while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r) else $error("divider did not go busy");
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> rem_r < divisor_r) else $error("partial remainder out of range");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("done held longer than one cycle");
`endif

endmodule
